// ===== rtl/core/chs_pkg.sv =====
// Shared constants and types for the cubic Hermite spline evaluator.
// No dependencies.
`default_nettype none

package chs_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int NUM_TERMS       = 4;
	localparam int NUM_STAGES      = 9;

	// Term order in the weighted sum.
	localparam int TERM_P0 = 0;
	localparam int TERM_M0 = 1;
	localparam int TERM_P1 = 2;
	localparam int TERM_M1 = 3;

	// Load enables for the two register stages inside a multiply lane.
	typedef struct packed {
		logic ld_mul;
		logic ld_sum;
	} chs_lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/chs_in_if.sv =====
// Input channel: curve parameter and one axis of segment end points and tangents.
// Depends on chs_pkg for default widths.
`default_nettype none

interface chs_in_if #(
	parameter int COORD_WIDTH = chs_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = chs_pkg::FRAC_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic        [FRAC_BITS:0]     param_t;
	logic signed [COORD_WIDTH-1:0] start_value;
	logic signed [COORD_WIDTH-1:0] start_tangent;
	logic signed [COORD_WIDTH-1:0] end_value;
	logic signed [COORD_WIDTH-1:0] end_tangent;

	modport source (
		output valid, param_t, start_value, start_tangent, end_value, end_tangent,
		input  ready
	);

	modport sink (
		input  valid, param_t, start_value, start_tangent, end_value, end_tangent,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/chs_out_if.sv =====
// Output channel: interpolated coordinate and saturation flag.
// Depends on chs_pkg for default widths.
`default_nettype none

interface chs_out_if #(
	parameter int COORD_WIDTH = chs_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] curve_value;
	logic                          saturated;

	modport source (
		output valid, curve_value, saturated,
		input  ready
	);

	modport sink (
		input  valid, curve_value, saturated,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/cubic_hermite_interpolator.sv =====
// Cubic Hermite spline evaluator, one coordinate per transfer.
// Each input transfer passes through register stages s1 to s9 before its result transfer.
// Throughput: one transfer per cycle while the output is ready; each stage loads when empty or when the next one moves.
// Reset clears the stage valid bits only; datapath registers are not reset.
// Depends on chs_pkg, chs_in_if, chs_out_if and chs_mac_lane.
`default_nettype none

module cubic_hermite_interpolator #(
	parameter int COORD_WIDTH = chs_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = chs_pkg::FRAC_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	chs_in_if.sink     sample,
	chs_out_if.source  result
);
	import chs_pkg::*;

	localparam int WGT_W  = FRAC_BITS + 3;
	localparam int SQ_W   = 2 * FRAC_BITS + 2;
	localparam int PROD_W = WGT_W + COORD_WIDTH;
	localparam int ACC_W  = PROD_W + 2;
	localparam int SH_W   = ACC_W - FRAC_BITS;
	localparam int TOP_W  = SH_W - COORD_WIDTH + 1;

	localparam logic [FRAC_BITS:0]           ONE_T  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [SQ_W-1:0]              RND_SQ = SQ_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [WGT_W-1:0]      ONE_W  = WGT_W'(1) << FRAC_BITS;
	localparam logic signed [ACC_W-1:0]      RND_AC = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Stage valid bits and load enables; index k is stage k+1.
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;

	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || result.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= sample.valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign sample.ready = en[0];

	// s1: capture, clamp t to one
	logic        [FRAC_BITS:0]     t_d;
	logic        [FRAC_BITS:0]     t_s1;
	logic signed [COORD_WIDTH-1:0] crd_s1 [NUM_TERMS];

	assign t_d = (sample.param_t > ONE_T) ? ONE_T : sample.param_t;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1             <= t_d;
			crd_s1[TERM_P0]  <= sample.start_value;
			crd_s1[TERM_M0]  <= sample.start_tangent;
			crd_s1[TERM_P1]  <= sample.end_value;
			crd_s1[TERM_M1]  <= sample.end_tangent;
		end
	end

	// s2: t squared
	logic        [SQ_W-1:0]        sq_d;
	logic        [SQ_W-1:0]        sq_rnd;
	logic        [FRAC_BITS:0]     t_s2;
	logic        [FRAC_BITS:0]     t2_s2;
	logic signed [COORD_WIDTH-1:0] crd_s2 [NUM_TERMS];

	assign sq_d   = t_s1 * t_s1;
	assign sq_rnd = sq_d + RND_SQ;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			t_s2   <= t_s1;
			t2_s2  <= sq_rnd[FRAC_BITS +: FRAC_BITS+1];
			crd_s2 <= crd_s1;
		end
	end

	// s3: t cubed
	logic        [SQ_W-1:0]        cu_d;
	logic        [SQ_W-1:0]        cu_rnd;
	logic        [FRAC_BITS:0]     t_s3;
	logic        [FRAC_BITS:0]     t2_s3;
	logic        [FRAC_BITS:0]     t3_s3;
	logic signed [COORD_WIDTH-1:0] crd_s3 [NUM_TERMS];

	assign cu_d   = t2_s2 * t_s2;
	assign cu_rnd = cu_d + RND_SQ;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s3   <= t_s2;
			t2_s3  <= t2_s2;
			t3_s3  <= cu_rnd[FRAC_BITS +: FRAC_BITS+1];
			crd_s3 <= crd_s2;
		end
	end

	// s4: basis weights
	logic signed [WGT_W-1:0]       tw;
	logic signed [WGT_W-1:0]       t2w;
	logic signed [WGT_W-1:0]       t3w;
	logic signed [WGT_W-1:0]       wgt_s4 [NUM_TERMS];
	logic signed [COORD_WIDTH-1:0] crd_s4 [NUM_TERMS];

	assign tw  = {2'b00, t_s3};
	assign t2w = {2'b00, t2_s3};
	assign t3w = {2'b00, t3_s3};

	always_ff @(posedge clk) begin
		if (en[3]) begin
			wgt_s4[TERM_P0] <= (t3w <<< 1) - (t2w <<< 1) - t2w + ONE_W;
			wgt_s4[TERM_M0] <= t3w - (t2w <<< 1) + tw;
			wgt_s4[TERM_P1] <= (t2w <<< 1) + t2w - (t3w <<< 1);
			wgt_s4[TERM_M1] <= t3w - t2w;
			crd_s4          <= crd_s3;
		end
	end

	// s5, s6: products in the lanes
	chs_lane_ctl_t            lane_ctl;
	logic signed [PROD_W-1:0] prod_s6 [NUM_TERMS];

	assign lane_ctl = '{ld_mul: en[4], ld_sum: en[5]};

	for (genvar i = 0; i < NUM_TERMS; i++) begin : g_lane
		chs_mac_lane #(
			.COORD_WIDTH(COORD_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.ctl    (lane_ctl),
			.weight (wgt_s4[i]),
			.coord  (crd_s4[i]),
			.product(prod_s6[i])
		);
	end

	// s7: pair sums
	logic signed [ACC_W-1:0] pa_s7;
	logic signed [ACC_W-1:0] pb_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			pa_s7 <= ACC_W'(prod_s6[TERM_P0]) + ACC_W'(prod_s6[TERM_M0]);
			pb_s7 <= ACC_W'(prod_s6[TERM_P1]) + ACC_W'(prod_s6[TERM_M1]);
		end
	end

	// s8: total with rounding bias
	logic signed [ACC_W-1:0] acc_s8;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			acc_s8 <= pa_s7 + pb_s7 + RND_AC;
		end
	end

	// s9: scale down, saturate, output register
	logic signed [SH_W-1:0]        shf;
	logic        [TOP_W-1:0]       top;
	logic                          in_rng;
	logic signed [COORD_WIDTH-1:0] val_d;
	logic signed [COORD_WIDTH-1:0] val_s9;
	logic                          sat_s9;

	assign shf    = SH_W'(acc_s8 >>> FRAC_BITS);
	assign top    = shf[SH_W-1:COORD_WIDTH-1];
	assign in_rng = (&top) || !(|top);
	assign val_d  = in_rng ? shf[COORD_WIDTH-1:0] : (shf[SH_W-1] ? C_MIN : C_MAX);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			val_s9 <= val_d;
			sat_s9 <= !in_rng;
		end
	end

	assign result.valid       = vld_q[NUM_STAGES-1];
	assign result.curve_value = val_s9;
	assign result.saturated   = sat_s9;

`ifndef SYNTH
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.saturated |->
			(result.curve_value == C_MAX) || (result.curve_value == C_MIN))
		else $error("saturated result not at a range limit");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (&vld_q) && !result.ready)
		else $error("input stalled with a free stage");

	a_t_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> t_s1 <= ONE_T)
		else $error("t above one after clamp");

	a_wgt_unity: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] |-> (wgt_s4[TERM_P0] + wgt_s4[TERM_P1]) == ONE_W)
		else $error("end point weights do not sum to one");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !vld_q[NUM_STAGES-2] |=> !result.valid)
		else $error("result repeated after transfer");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/chs_mac_lane.sv =====
// One weight-by-coordinate product lane: split multiply, then recombine.
// Depends on chs_pkg (lane control struct).
`default_nettype none

module chs_mac_lane #(
	parameter int COORD_WIDTH = chs_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = chs_pkg::FRAC_BITS_DEF
) (
	input  wire                                       clk,
	input  chs_pkg::chs_lane_ctl_t                    ctl,
	input  wire signed [FRAC_BITS+2:0]                weight,
	input  wire signed [COORD_WIDTH-1:0]              coord,
	output logic signed [FRAC_BITS+3+COORD_WIDTH-1:0] product
);
	import chs_pkg::*;

	localparam int WGT_W  = FRAC_BITS + 3;
	localparam int LO_W   = COORD_WIDTH / 2;
	localparam int HI_W   = COORD_WIDTH - LO_W;
	localparam int PL_W   = WGT_W + LO_W + 1;
	localparam int PH_W   = WGT_W + HI_W;
	localparam int PROD_W = WGT_W + COORD_WIDTH;

	logic signed [LO_W:0]     c_lo;
	logic signed [HI_W-1:0]   c_hi;
	logic signed [PL_W-1:0]   pl_d;
	logic signed [PH_W-1:0]   ph_d;
	logic signed [PL_W-1:0]   pl_s5;
	logic signed [PH_W-1:0]   ph_s5;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] prod_s6;

	assign c_lo = {1'b0, coord[LO_W-1:0]};
	assign c_hi = coord[COORD_WIDTH-1:LO_W];
	assign pl_d = weight * c_lo;
	assign ph_d = weight * c_hi;

	assign prod_d = (PROD_W'(ph_s5) <<< LO_W) + PROD_W'(pl_s5);

	always_ff @(posedge clk) begin
		if (ctl.ld_mul) begin
			pl_s5 <= pl_d;
			ph_s5 <= ph_d;
		end
		if (ctl.ld_sum) begin
			prod_s6 <= prod_d;
		end
	end

	assign product = prod_s6;

endmodule

`default_nettype wire
